### rtl/mmtp_pkg.sv
// Shared types and constants for the multi-mode trajectory predictor.
package mmtp_pkg;

    typedef enum logic [1:0] {
        MODE_CV = 2'd0,
        MODE_LK = 2'd1,
        MODE_LC = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        REG_LANE_WIDTH = 3'd0,
        REG_AGE_SAT    = 3'd1,
        REG_BASE_CONF  = 3'd2,
        REG_MIN_CONF   = 3'd3,
        REG_PROB_CV    = 3'd4,
        REG_PROB_LK    = 3'd5,
        REG_PROB_LC    = 3'd6,
        REG_UNUSED     = 3'd7
    } t_reg;

    localparam logic [15:0] RST_LANE_WIDTH = 16'd896;
    localparam logic [15:0] RST_AGE_SAT    = 16'd50;
    localparam logic [15:0] RST_BASE_CONF  = 16'd45875;
    localparam logic [15:0] RST_MIN_CONF   = 16'd6554;
    localparam logic [15:0] RST_PROB_CV    = 16'd45875;
    localparam logic [15:0] RST_PROB_LK    = 16'd13107;
    localparam logic [15:0] RST_PROB_LC    = 16'd6554;

    typedef struct packed {
        logic [15:0] lane_width;
        logic [15:0] age_sat;
        logic [15:0] base_conf;
        logic [15:0] min_conf;
        logic [15:0] prob_cv;
        logic [15:0] prob_lk;
        logic [15:0] prob_lc;
    } t_cfg;

    typedef struct packed {
        logic [15:0]        id;
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic               vx_neg;
        logic               vy_neg;
        logic [15:0]        avx;
        logic [15:0]        avy;
        logic [15:0]        spd;
        logic [15:0]        conf;
        logic               rej;
    } t_obj;

endpackage

### rtl/mmtp_front.sv
// Object front pipeline: confidence divide, speed square root, reject decision.
module mmtp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_load,
    input  logic [15:0]        i_object_id,
    input  logic signed [23:0] i_pos_x,
    input  logic signed [23:0] i_pos_y,
    input  logic signed [15:0] i_vel_x,
    input  logic signed [15:0] i_vel_y,
    input  logic [15:0]        i_track_age,
    input  logic               i_is_static,
    input  mmtp_pkg::t_cfg     i_cfg,
    output mmtp_pkg::t_obj     o_obj,
    output logic               o_obj_valid
);

    localparam int NST   = 8;
    localparam int STEPS = 4;

    typedef struct packed {
        logic [15:0]        id;
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic               vx_neg;
        logic               vy_neg;
        logic [15:0]        avx;
        logic [15:0]        avy;
        logic               stat;
        logic [15:0]        m;
        logic [15:0]        sat;
        logic [31:0]        prod;
        logic [31:0]        sqx;
        logic [31:0]        sqy;
        logic [15:0]        drem;
        logic [15:0]        dlo;
        logic [15:0]        q;
        logic [31:0]        sin;
        logic [18:0]        srem;
        logic [15:0]        root;
    } t_fr;

    t_fr        r_st [NST];
    t_fr        n_st [NST];
    logic [NST-1:0] r_v;

    function automatic t_fr div_step(input t_fr a);
        t_fr         b;
        logic [16:0] t;
        b = a;
        t = {a.drem, a.dlo[15]};
        b.dlo = {a.dlo[14:0], 1'b0};
        if (t >= {1'b0, a.sat}) begin
            b.drem = 16'(t - {1'b0, a.sat});
            b.q    = {a.q[14:0], 1'b1};
        end else begin
            b.drem = t[15:0];
            b.q    = {a.q[14:0], 1'b0};
        end
        return b;
    endfunction

    function automatic t_fr sqrt_step(input t_fr a);
        t_fr         b;
        logic [18:0] t;
        logic [18:0] trial;
        b = a;
        t     = {a.srem[16:0], a.sin[31:30]};
        trial = {1'b0, a.root, 2'b01};
        b.sin = {a.sin[29:0], 2'b00};
        if (t >= trial) begin
            b.srem = t - trial;
            b.root = {a.root[14:0], 1'b1};
        end else begin
            b.srem = t;
            b.root = {a.root[14:0], 1'b0};
        end
        return b;
    endfunction

    always_comb begin
        logic [15:0] sat;
        t_fr         w;
        sat = (i_cfg.age_sat == 16'd0) ? 16'd1 : i_cfg.age_sat;
        for (int i = 0; i < NST; i++) begin
            n_st[i] = r_st[i];
        end

        n_st[0].id     = i_object_id;
        n_st[0].x      = i_pos_x;
        n_st[0].y      = i_pos_y;
        n_st[0].vx_neg = i_vel_x[15];
        n_st[0].vy_neg = i_vel_y[15];
        n_st[0].avx    = i_vel_x[15] ? 16'(~i_vel_x + 16'sd1) : 16'(i_vel_x);
        n_st[0].avy    = i_vel_y[15] ? 16'(~i_vel_y + 16'sd1) : 16'(i_vel_y);
        n_st[0].stat   = i_is_static;
        n_st[0].sat    = sat;
        n_st[0].m      = (i_track_age < sat) ? i_track_age : sat;

        n_st[1]      = r_st[0];
        n_st[1].prod = r_st[0].m * i_cfg.base_conf;
        n_st[1].sqx  = r_st[0].avx * r_st[0].avx;
        n_st[1].sqy  = r_st[0].avy * r_st[0].avy;

        n_st[2]      = r_st[1];
        n_st[2].drem = r_st[1].prod[31:16];
        n_st[2].dlo  = r_st[1].prod[15:0];
        n_st[2].q    = 16'd0;
        n_st[2].sin  = r_st[1].sqx + r_st[1].sqy;
        n_st[2].srem = 19'd0;
        n_st[2].root = 16'd0;

        for (int s = 3; s < 7; s++) begin
            w = r_st[s-1];
            for (int j = 0; j < STEPS; j++) begin
                w = div_step(w);
                w = sqrt_step(w);
            end
            n_st[s] = w;
        end

        n_st[7]      = r_st[6];
        n_st[7].root = r_st[6].root + 16'((r_st[6].srem > {3'b0, r_st[6].root}) ? 1 : 0);
        n_st[7].stat = r_st[6].stat || (r_st[6].q < i_cfg.min_conf);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_adv) begin
            r_v <= {r_v[NST-2:0], i_load};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < NST; i++) begin
                r_st[i] <= n_st[i];
            end
        end
    end

    assign o_obj_valid = r_v[NST-1];
    assign o_obj.id     = r_st[NST-1].id;
    assign o_obj.x      = r_st[NST-1].x;
    assign o_obj.y      = r_st[NST-1].y;
    assign o_obj.vx_neg = r_st[NST-1].vx_neg;
    assign o_obj.vy_neg = r_st[NST-1].vy_neg;
    assign o_obj.avx    = r_st[NST-1].avx;
    assign o_obj.avy    = r_st[NST-1].avy;
    assign o_obj.spd    = r_st[NST-1].root;
    assign o_obj.conf   = r_st[NST-1].q;
    assign o_obj.rej    = r_st[NST-1].stat;

endmodule

### rtl/multi_mode_trajectory_predictor.sv
// Top level: config registers, front pipeline and waypoint generator.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+------------------------------------
//  object in | start, busy               | i_object_id .. i_is_static
//  config    | i_cfg_valid, o_cfg_ready  | i_cfg_index, i_cfg_data
//  waypoint  | o_valid (strobe)          | o_out_object_id .. o_last
//
// An object passes through the front pipeline (divider and square root, four
// steps per stage), then the generator emits 3*WAYPOINTS words, one per
// cycle. A rejected object is dropped when taken. The generator sets the
// pace: objects enter back to back until the pipeline backs up behind it
// (busy). Reset is synchronous and clears all control and config registers.
module multi_mode_trajectory_predictor #(
    parameter int WAYPOINTS = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [15:0]        i_object_id,
    input  logic signed [23:0] i_pos_x,
    input  logic signed [23:0] i_pos_y,
    input  logic signed [15:0] i_vel_x,
    input  logic signed [15:0] i_vel_y,
    input  logic [15:0]        i_track_age,
    input  logic               i_is_static,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output logic               o_valid,
    output logic [15:0]        o_out_object_id,
    output logic [1:0]         o_mode,
    output logic [3:0]         o_step_index,
    output logic signed [23:0] o_way_x,
    output logic signed [23:0] o_way_y,
    output logic [15:0]        o_way_speed,
    output logic [15:0]        o_confidence,
    output logic [15:0]        o_probability,
    output logic               o_last
);

    localparam int STEP_W = $clog2(WAYPOINTS + 1);
    localparam int PW     = 16 + STEP_W;
    localparam int SUMW   = ((PW > 24) ? PW : 24) + 2;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(WAYPOINTS - 1);

    mmtp_pkg::t_cfg  r_cfg;
    mmtp_pkg::t_obj  fr_obj;
    logic            fr_valid;
    logic            adv;
    logic            take;

    mmtp_pkg::t_obj  r_obj;
    logic            r_act;
    mmtp_pkg::t_mode r_mode;
    logic [STEP_W-1:0] r_step;

    logic [STEP_W-1:0]   m;
    logic [PW-1:0]       pmx;
    logic [PW-1:0]       lat2;
    logic [PW-1:0]       hx;
    logic [PW-1:0]       dy_mag;
    logic                lc_in;
    logic signed [SUMW-1:0] dx;
    logic signed [SUMW-1:0] dy;
    logic [STEP_W+3:0]   step_ext;

    logic signed [23:0] n_way_x;
    logic signed [23:0] n_way_y;
    logic [15:0]        n_way_speed;
    logic [15:0]        n_probability;
    logic               n_last;

    function automatic logic signed [23:0] sat24(input logic signed [SUMW-1:0] v);
        if (v > SUMW'(24'sh7FFFFF)) begin
            return 24'sh7FFFFF;
        end else if (v < -SUMW'(25'sh0800000)) begin
            return -24'sh800000;
        end
        return v[23:0];
    endfunction

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lane_width <= mmtp_pkg::RST_LANE_WIDTH;
            r_cfg.age_sat    <= mmtp_pkg::RST_AGE_SAT;
            r_cfg.base_conf  <= mmtp_pkg::RST_BASE_CONF;
            r_cfg.min_conf   <= mmtp_pkg::RST_MIN_CONF;
            r_cfg.prob_cv    <= mmtp_pkg::RST_PROB_CV;
            r_cfg.prob_lk    <= mmtp_pkg::RST_PROB_LK;
            r_cfg.prob_lc    <= mmtp_pkg::RST_PROB_LC;
        end else if (i_cfg_valid) begin
            case (mmtp_pkg::t_reg'(i_cfg_index))
                mmtp_pkg::REG_LANE_WIDTH: r_cfg.lane_width <= i_cfg_data;
                mmtp_pkg::REG_AGE_SAT:    r_cfg.age_sat    <= i_cfg_data;
                mmtp_pkg::REG_BASE_CONF:  r_cfg.base_conf  <= i_cfg_data;
                mmtp_pkg::REG_MIN_CONF:   r_cfg.min_conf   <= i_cfg_data;
                mmtp_pkg::REG_PROB_CV:    r_cfg.prob_cv    <= i_cfg_data;
                mmtp_pkg::REG_PROB_LK:    r_cfg.prob_lk    <= i_cfg_data;
                mmtp_pkg::REG_PROB_LC:    r_cfg.prob_lc    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign take = !r_act || (r_mode == mmtp_pkg::MODE_LC && r_step == STEP_LAST);
    assign adv  = !fr_valid || take;
    assign busy = !adv || !i_rst_n;

    mmtp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_load      (start),
        .i_object_id (i_object_id),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_vel_x     (i_vel_x),
        .i_vel_y     (i_vel_y),
        .i_track_age (i_track_age),
        .i_is_static (i_is_static),
        .i_cfg       (r_cfg),
        .o_obj       (fr_obj),
        .o_obj_valid (fr_valid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act   <= 1'b0;
            r_mode  <= mmtp_pkg::MODE_CV;
            r_step  <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_act;
            if (take) begin
                r_act  <= fr_valid && !fr_obj.rej;
                r_mode <= mmtp_pkg::MODE_CV;
                r_step <= '0;
            end else if (r_step == STEP_LAST) begin
                r_step <= '0;
                r_mode <= (r_mode == mmtp_pkg::MODE_CV) ? mmtp_pkg::MODE_LK
                                                        : mmtp_pkg::MODE_LC;
            end else begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_obj <= fr_obj;
        end
    end

    always_comb begin
        m      = r_step + 1'b1;
        pmx    = PW'(r_obj.avx) * PW'(m);
        lat2   = PW'(r_obj.avy) * PW'(m);
        hx     = (pmx + 1'b1) >> 1;
        dx     = r_obj.vx_neg ? -SUMW'(hx) : SUMW'(hx);
        lc_in  = (lat2 < PW'({r_cfg.lane_width, 1'b0})) && (r_obj.avy != 16'd0);
        if (lc_in) begin
            dy_mag = (lat2 + 1'b1) >> 1;
        end else if (r_obj.avy != 16'd0) begin
            dy_mag = PW'(r_cfg.lane_width);
        end else begin
            dy_mag = '0;
        end
        dy       = r_obj.vy_neg ? -SUMW'(dy_mag) : SUMW'(dy_mag);
        step_ext = {4'b0, r_step};
        n_way_x  = sat24(SUMW'(r_obj.x) + dx);
        n_last   = 1'b0;
        case (r_mode)
            mmtp_pkg::MODE_CV: begin
                n_way_y       = sat24(SUMW'(r_obj.y) + SUMW'(r_obj.vy_neg ? -SUMW'(
                                ((PW'(r_obj.avy) * PW'(m)) + 1'b1) >> 1)
                                : SUMW'(((PW'(r_obj.avy) * PW'(m)) + 1'b1) >> 1)));
                n_way_speed   = r_obj.spd;
                n_probability = r_cfg.prob_cv;
            end
            mmtp_pkg::MODE_LK: begin
                n_way_y       = r_obj.y;
                n_way_speed   = r_obj.avx;
                n_probability = r_cfg.prob_lk;
            end
            default: begin
                n_way_y       = sat24(SUMW'(r_obj.y) + dy);
                n_way_speed   = lc_in ? r_obj.spd : r_obj.avx;
                n_probability = r_cfg.prob_lc;
                n_last        = (r_step == STEP_LAST);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        o_out_object_id <= r_obj.id;
        o_mode          <= r_mode;
        o_step_index    <= step_ext[3:0];
        o_way_x         <= n_way_x;
        o_way_y         <= n_way_y;
        o_way_speed     <= n_way_speed;
        o_confidence    <= r_obj.conf;
        o_probability   <= n_probability;
        o_last          <= n_last;
    end

    a_last_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_mode == mmtp_pkg::MODE_LC)
        else $error("last word outside lane change mode");

    a_run_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |=> o_valid)
        else $error("gap inside a waypoint run");

    a_mode_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_mode != 2'd3)
        else $error("illegal mode code on output");

endmodule
